FILE: hdl/rs2r_pkg.sv
// Shared types, codes and helpers for the raster sample to RGBA8 converter.
package rs2r_pkg;

  localparam int unsigned LaneCount = 4;
  localparam int unsigned SampleW   = 64;
  localparam int unsigned ColourW   = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 3;

  typedef enum logic [1:0] {
    KIND_UNSIGNED = 2'd0,
    KIND_SIGNED   = 2'd1,
    KIND_FLOAT    = 2'd2,
    KIND_BAD      = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    MODE_WHITE_ZERO = 3'd0,
    MODE_BLACK_ZERO = 3'd1,
    MODE_RGB        = 3'd2,
    MODE_PALETTE    = 3'd3,
    MODE_OTHER      = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_KIND    = 2'd1,
    CFG_MODE    = 2'd2,
    CFG_SAMPLES = 2'd3
  } cfg_idx_e;

  // Decoded sample format handed to every lane.
  typedef struct packed {
    logic [2:0] width_code;
    kind_e      kind;
  } lane_cfg_t;

endpackage

FILE: hdl/rs2r_lane.sv
// One conversion lane: a raw sample word to an 8-bit channel value, registered.
module rs2r_lane (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  rs2r_pkg::lane_cfg_t            cfg_i,
  input  logic [rs2r_pkg::SampleW-1:0]   raw_i,
  output logic [7:0]                     chan_o
);

  logic [7:0]  chan_d;
  logic [7:0]  chan_q;
  logic        neg;
  logic [7:0]  uval;
  logic [7:0]  fval32;
  logic [7:0]  fval64;
  logic [23:0] man32;
  logic [52:0] man64;
  logic [31:0] prod32;
  logic [60:0] prod64;
  logic [7:0]  e32;
  logic [10:0] e64;

  // Pick the sign and unsigned mapping per width
  always_comb begin
    neg  = 1'b0;
    uval = 8'd0;
    unique case (cfg_i.width_code)
      3'd0: uval = {8{raw_i[0]}};
      3'd1: uval = {4{raw_i[1:0]}};
      3'd2: uval = {2{raw_i[3:0]}};
      3'd3: begin uval = raw_i[7:0];   neg = raw_i[7];  end
      3'd4: begin uval = raw_i[15:8];  neg = raw_i[15]; end
      3'd5: begin uval = raw_i[31:24]; neg = raw_i[31]; end
      3'd6: begin uval = raw_i[63:56]; neg = raw_i[63]; end
      default: uval = 8'd0;
    endcase
  end

  // Float: value in (0,1) is m*2^(e-bias); floor(x*255) from the full mantissa
  always_comb begin
    e32    = raw_i[30:23];
    man32  = {1'b1, raw_i[22:0]};
    prod32 = ({8'd0, man32} << 8) - {8'd0, man32};
    fval32 = 8'd0;
    if (raw_i[31] || (e32 == 8'd0)) begin
      fval32 = 8'd0;
    end else if (e32 == 8'hFF) begin
      fval32 = (raw_i[22:0] != 23'd0) ? 8'd0 : 8'd255;
    end else if (e32 >= 8'd127) begin
      fval32 = 8'd255;
    end else if (e32 >= 8'd118) begin
      fval32 = 8'(prod32 >> (8'd23 + (8'd127 - e32)));
    end
    e64    = raw_i[62:52];
    man64  = {1'b1, raw_i[51:0]};
    prod64 = ({8'd0, man64} << 8) - {8'd0, man64};
    fval64 = 8'd0;
    if (raw_i[63] || (e64 == 11'd0)) begin
      fval64 = 8'd0;
    end else if (e64 == 11'h7FF) begin
      fval64 = (raw_i[51:0] != 52'd0) ? 8'd0 : 8'd255;
    end else if (e64 >= 11'd1023) begin
      fval64 = 8'd255;
    end else if (e64 >= 11'd1014) begin
      fval64 = 8'(prod64 >> (11'd52 + (11'd1023 - e64)));
    end
  end

  // Select by kind
  always_comb begin
    case (cfg_i.kind)
      rs2r_pkg::KIND_SIGNED: chan_d = neg ? 8'd0 : uval;
      rs2r_pkg::KIND_FLOAT:  chan_d = (cfg_i.width_code == 3'd5) ? fval32 : fval64;
      default:               chan_d = uval;
    endcase
  end

  // Hold the channel until the next item
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

FILE: hdl/rs2r_merge.sv
// Merge stage: packs lane channels, applies the colour mode and the error flag.
module rs2r_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  logic                          err_i,
  input  rs2r_pkg::mode_e               mode_i,
  input  logic [7:0]                    chan_i [rs2r_pkg::LaneCount],
  output logic                          vld_o,
  output logic [rs2r_pkg::ColourW-1:0]  colour_o,
  output logic                          err_o
);

  logic                         vld_q;
  logic [rs2r_pkg::ColourW-1:0] colour_d;
  logic [rs2r_pkg::ColourW-1:0] colour_q;
  logic                         err_q;
  logic [7:0]                   grey;

  // Build the packed colour
  always_comb begin
    grey     = (mode_i == rs2r_pkg::MODE_WHITE_ZERO) ? ~chan_i[0] : chan_i[0];
    colour_d = '0;
    if (!err_i) begin
      case (mode_i)
        rs2r_pkg::MODE_WHITE_ZERO, rs2r_pkg::MODE_BLACK_ZERO:
          colour_d = {8'hFF, grey, grey, grey};
        rs2r_pkg::MODE_RGB:
          colour_d = {8'hFF, chan_i[2], chan_i[1], chan_i[0]};
        default:
          colour_d = {chan_i[3], chan_i[2], chan_i[1], chan_i[0]};
      endcase
    end
  end

  // Advance the strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      colour_q <= colour_d;
      err_q    <= err_i;
    end
  end

  assign vld_o    = vld_q;
  assign colour_o = colour_q;
  assign err_o    = err_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && err_q |-> colour_q == '0) else $error("error item with colour");
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_i |=> vld_q) else $error("result strobe lost");
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_i && !err_i && (mode_i == rs2r_pkg::MODE_RGB) |=> colour_q[31:24] == 8'hFF)
    else $error("alpha not forced");

endmodule

FILE: hdl/raster_sample_to_rgba8.sv
// Top level of the raster sample to RGBA8 converter.
// done follows start through the lane register, then the merge register.
// Throughput: one item per clock; start may be high every cycle.
// busy is never raised: the four lanes and merge stage are fully pipelined.
// Reset clears the pipeline strobes and loads the register defaults
// (8-bit unsigned RGB, three samples); results cannot be stalled.
module raster_sample_to_rgba8 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [rs2r_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rs2r_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [rs2r_pkg::SampleW-1:0]  sample_first_i,
  input  logic [rs2r_pkg::SampleW-1:0]  sample_second_i,
  input  logic [rs2r_pkg::SampleW-1:0]  sample_third_i,
  input  logic [rs2r_pkg::SampleW-1:0]  sample_fourth_i,
  output logic                          done,
  output logic [rs2r_pkg::ColourW-1:0]  packed_colour_o,
  output logic                          format_error_o
);

  logic [2:0] width_q;
  logic [1:0] kind_q;
  logic [2:0] mode_q;
  logic [2:0] spp_q;
  logic       acc;
  logic       err_d;
  logic       vld1_q;
  logic       err1_q;
  rs2r_pkg::mode_e mode_d;
  rs2r_pkg::mode_e mode1_q;
  rs2r_pkg::lane_cfg_t lcfg;
  logic [rs2r_pkg::SampleW-1:0] raw [rs2r_pkg::LaneCount];
  logic [7:0] chan [rs2r_pkg::LaneCount];

  assign busy = 1'b0;
  assign acc  = start && !busy;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 3'd3;
      kind_q  <= rs2r_pkg::KIND_UNSIGNED;
      mode_q  <= rs2r_pkg::MODE_RGB;
      spp_q   <= 3'd3;
    end else if (cfg_we_i) begin
      unique case (rs2r_pkg::cfg_idx_e'(cfg_idx_i))
        rs2r_pkg::CFG_WIDTH:   width_q <= cfg_data_i;
        rs2r_pkg::CFG_KIND:    kind_q  <= cfg_data_i[1:0];
        rs2r_pkg::CFG_MODE:    mode_q  <= cfg_data_i;
        rs2r_pkg::CFG_SAMPLES: spp_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Check the format combination
  always_comb begin
    err_d  = 1'b0;
    mode_d = rs2r_pkg::MODE_OTHER;
    if (mode_q <= rs2r_pkg::MODE_PALETTE) mode_d = rs2r_pkg::mode_e'(mode_q);
    if (width_q == 3'd7 || kind_q == rs2r_pkg::KIND_BAD) err_d = 1'b1;
    if (width_q < 3'd3 && kind_q != rs2r_pkg::KIND_UNSIGNED) err_d = 1'b1;
    if (kind_q == rs2r_pkg::KIND_FLOAT && width_q < 3'd5) err_d = 1'b1;
    if (mode_d == rs2r_pkg::MODE_PALETTE) err_d = 1'b1;
    if (mode_d == rs2r_pkg::MODE_OTHER && spp_q != 3'd4) err_d = 1'b1;
    lcfg.width_code = width_q;
    lcfg.kind       = rs2r_pkg::kind_e'(kind_q);
  end

  assign raw[0] = sample_first_i;
  assign raw[1] = sample_second_i;
  assign raw[2] = sample_third_i;
  assign raw[3] = sample_fourth_i;

  for (genvar l = 0; l < rs2r_pkg::LaneCount; l++) begin : g_lane
    rs2r_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (acc),
      .cfg_i  (lcfg),
      .raw_i  (raw[l]),
      .chan_o (chan[l])
    );
  end

  // Advance the first stage strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= acc;
    end
  end

  // Hold mode and error beside the lanes
  always_ff @(posedge clk_i) begin
    if (acc) begin
      err1_q  <= err_d;
      mode1_q <= mode_d;
    end
  end

  rs2r_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (vld1_q),
    .err_i    (err1_q),
    .mode_i   (mode1_q),
    .chan_i   (chan),
    .vld_o    (done),
    .colour_o (packed_colour_o),
    .err_o    (format_error_o)
  );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the raster sample to RGBA8 converter.
module tb_top;

  // One expected pixel result
  typedef struct {
    logic [rs2r_pkg::ColourW-1:0] colour;
    logic                         err;
  } pixel_result_t;

  // Predicts converted pixels and checks them in order against the block
  class colour_scoreboard;
    logic [2:0]    width_code;
    logic [1:0]    kind;
    logic [2:0]    mode;
    logic [2:0]    samples;
    pixel_result_t expected_pixels[$];
    int            failures;

    function new();
      width_code = 3'd3;
      kind       = rs2r_pkg::KIND_UNSIGNED;
      mode       = rs2r_pkg::MODE_RGB;
      samples    = 3'd3;
      failures   = 0;
    endfunction

    function void set_reg(logic [rs2r_pkg::CfgIdxW-1:0] idx,
                          logic [rs2r_pkg::CfgDataW-1:0] val);
      case (idx)
        rs2r_pkg::CFG_WIDTH:   width_code = val;
        rs2r_pkg::CFG_KIND:    kind = val[1:0];
        rs2r_pkg::CFG_MODE:    mode = val;
        rs2r_pkg::CFG_SAMPLES: samples = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function logic [7:0] double_to8(logic [63:0] bits);
      real x;
      if (bits[62:52] == 11'h7FF && bits[51:0] != 0) return 8'd0;
      x = $bitstoreal(bits);
      if (!(x > 0.0)) return 8'd0;
      if (x >= 1.0) return 8'd255;
      return 8'($rtoi(x * 255.0));
    endfunction

    // Widen binary32 to binary64 exactly; subnormals scale to zero anyway
    function logic [7:0] single_to8(logic [31:0] bits);
      logic [10:0] e64;
      if (bits[30:23] == 8'hFF)
        return (bits[22:0] == 0 && !bits[31]) ? 8'd255 : 8'd0;
      if (bits[30:23] == 8'h00) return 8'd0;
      e64 = 11'(bits[30:23]) + 11'd896;
      return double_to8({bits[31], e64, bits[22:0], 29'd0});
    endfunction

    function logic [7:0] sample_to8(logic [63:0] raw, int n);
      logic [63:0] v;
      v = (n >= 64) ? raw : (raw & ((64'd1 << n) - 64'd1));
      if (kind == rs2r_pkg::KIND_FLOAT)
        return (n == 32) ? single_to8(v[31:0]) : double_to8(v);
      if (kind == rs2r_pkg::KIND_SIGNED && v[n-1]) return 8'd0;
      if (n < 8) return 8'((64'd255 * v) / ((64'd1 << n) - 64'd1));
      return 8'(v >> (n - 8));
    endfunction

    // Work out the result of one accepted pixel
    function void note(logic [63:0] s0, logic [63:0] s1, logic [63:0] s2,
                       logic [63:0] s3);
      pixel_result_t r;
      int            n;
      logic [7:0]    g;
      r.err    = 1'b0;
      r.colour = '0;
      n = 0;
      if (width_code > 3'd6 || kind == rs2r_pkg::KIND_BAD) r.err = 1'b1;
      else n = 1 << width_code;
      if (!r.err && n < 8 && kind != rs2r_pkg::KIND_UNSIGNED) r.err = 1'b1;
      if (!r.err && kind == rs2r_pkg::KIND_FLOAT && n < 32) r.err = 1'b1;
      if (!r.err) begin
        if (mode == rs2r_pkg::MODE_WHITE_ZERO || mode == rs2r_pkg::MODE_BLACK_ZERO) begin
          g = sample_to8(s0, n);
          if (mode == rs2r_pkg::MODE_WHITE_ZERO) g = 8'd255 - g;
          r.colour = {8'hFF, g, g, g};
        end else if (mode == rs2r_pkg::MODE_RGB) begin
          r.colour = {8'hFF, sample_to8(s2, n), sample_to8(s1, n), sample_to8(s0, n)};
        end else if (mode == rs2r_pkg::MODE_PALETTE) begin
          r.err = 1'b1;
        end else if (samples == 3'd4) begin
          r.colour = {sample_to8(s3, n), sample_to8(s2, n), sample_to8(s1, n),
                      sample_to8(s0, n)};
        end else begin
          r.err = 1'b1;
        end
      end
      if (r.err) r.colour = '0;
      expected_pixels.push_back(r);
    endfunction

    // Compare one result with the oldest expectation
    function void check(logic [rs2r_pkg::ColourW-1:0] colour, logic err);
      pixel_result_t e;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result colour=%h err=%b", $time, colour, err);
        failures++;
        return;
      end
      e = expected_pixels.pop_front();
      if (colour !== e.colour) begin
        $display("%0t: packed_colour expected %h actual %h", $time, e.colour, colour);
        failures++;
      end
      if (err !== e.err) begin
        $display("%0t: format_error expected %b actual %b", $time, e.err, err);
        failures++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic                          cfg_we_i;
  logic [rs2r_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [rs2r_pkg::CfgDataW-1:0] cfg_data_i;
  logic [rs2r_pkg::SampleW-1:0]  sample_first_i;
  logic [rs2r_pkg::SampleW-1:0]  sample_second_i;
  logic [rs2r_pkg::SampleW-1:0]  sample_third_i;
  logic [rs2r_pkg::SampleW-1:0]  sample_fourth_i;
  logic                          done;
  logic [rs2r_pkg::ColourW-1:0]  packed_colour_o;
  logic                          format_error_o;

  colour_scoreboard pixel_sb = new();
  int               stall_cycles;
  bit               allow_idle;

  raster_sample_to_rgba8 DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .sample_first_i  (sample_first_i),
    .sample_second_i (sample_second_i),
    .sample_third_i  (sample_third_i),
    .sample_fourth_i (sample_fourth_i),
    .done            (done),
    .packed_colour_o (packed_colour_o),
    .format_error_o  (format_error_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Check every result strobe
  always @(posedge clk_i) begin
    if (done) pixel_sb.check(packed_colour_o, format_error_o);
  end

  // Watchdog on cycles with no progress
  always @(posedge clk_i) begin
    if ((start && !busy) || done || !rst_ni) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 3000) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Wait until all results are in, then let the pipeline settle
  task automatic drain();
    while (pixel_sb.pending() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [rs2r_pkg::CfgIdxW-1:0] idx,
                           logic [rs2r_pkg::CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pixel_sb.set_reg(idx, val);
  endtask

  task automatic configure(logic [2:0] w, logic [1:0] k, logic [2:0] m, logic [2:0] s);
    drain();
    write_reg(rs2r_pkg::CFG_WIDTH, w);
    write_reg(rs2r_pkg::CFG_KIND, {1'b0, k});
    write_reg(rs2r_pkg::CFG_MODE, m);
    write_reg(rs2r_pkg::CFG_SAMPLES, s);
  endtask

  // Offer one pixel, hold until accepted, then idle at random
  task automatic send_pixel(logic [63:0] s0, logic [63:0] s1, logic [63:0] s2,
                            logic [63:0] s3);
    start           <= 1'b1;
    sample_first_i  <= s0;
    sample_second_i <= s1;
    sample_third_i  <= s2;
    sample_fourth_i <= s3;
    do @(posedge clk_i); while (busy);
    pixel_sb.note(s0, s1, s2, s3);
    if (allow_idle && $urandom_range(0, 99) < 18) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic end_burst();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random sample; for float kinds, biased towards values that decode to mid-range colours
  function automatic logic [63:0] random_sample(logic [1:0] k, logic [2:0] w);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return r;
      default: begin
        if (k == rs2r_pkg::KIND_FLOAT && w == 3'd5)
          r[30:23] = 8'($urandom_range(112, 128));
        else if (k == rs2r_pkg::KIND_FLOAT)
          r[62:52] = 11'($urandom_range(1008, 1024));
        if (k == rs2r_pkg::KIND_FLOAT && $urandom_range(0, 7) != 0) begin
          if (w == 3'd5) r[31] = 1'b0;
          else r[63] = 1'b0;
        end
        return r;
      end
    endcase
  endfunction

  initial begin
    logic [2:0] w;
    logic [1:0] k;
    logic [2:0] m;
    logic [2:0] s;
    rst_ni          <= 1'b0;
    start           <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= '0;
    cfg_data_i      <= '0;
    sample_first_i  <= '0;
    sample_second_i <= '0;
    sample_third_i  <= '0;
    sample_fourth_i <= '0;
    stall_cycles    <= 0;
    allow_idle      = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: 8-bit unsigned RGB
    send_pixel('1, 64'h0, 64'h80, 64'hFFFF_FFFF_FFFF_FF7F);
    end_burst();

    // Float32 RGBA: one, NaN, negative, half, infinities, zero
    configure(3'd5, rs2r_pkg::KIND_FLOAT, rs2r_pkg::MODE_OTHER, 3'd4);
    send_pixel(64'h3F80_0000, 64'h7FC0_0000, 64'hBF00_0000, 64'h3F00_0000);
    send_pixel(64'h7F80_0000, 64'hFF80_0000, 64'h0, 64'hFFFF_FFFF_3F7F_FFFF);
    end_burst();
    // Float64 grey and RGB
    configure(3'd6, rs2r_pkg::KIND_FLOAT, rs2r_pkg::MODE_BLACK_ZERO, 3'd1);
    send_pixel(64'h3FE0_0000_0000_0000, 0, 0, 0);
    send_pixel(64'h7FF8_0000_0000_0000, 0, 0, 0);
    end_burst();
    configure(3'd6, rs2r_pkg::KIND_FLOAT, rs2r_pkg::MODE_RGB, 3'd0);
    send_pixel(64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000,
               64'h7FF0_0000_0000_0000, 64'h0000_0000_0000_0001);
    end_burst();
    // Signed extremes, white-is-zero and RGBA
    configure(3'd4, rs2r_pkg::KIND_SIGNED, rs2r_pkg::MODE_WHITE_ZERO, 3'd7);
    send_pixel(64'hFFFF_FFFF_FFFF_7FFF, 0, 0, 0);
    send_pixel(64'h0000_0000_0000_8000, 0, 0, 0);
    end_burst();
    configure(3'd6, rs2r_pkg::KIND_SIGNED, rs2r_pkg::MODE_OTHER, 3'd4);
    send_pixel(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 0, '1);
    end_burst();
    // One-bit unsigned with bits above the width set
    configure(3'd0, rs2r_pkg::KIND_UNSIGNED, rs2r_pkg::MODE_RGB, 3'd3);
    send_pixel('1, 64'hFFFF_FFFF_FFFF_FFFE, 64'h1, 64'h0);
    end_burst();
    configure(3'd2, rs2r_pkg::KIND_UNSIGNED, 3'd7, 3'd4);
    send_pixel(64'h5, 64'hF, 64'hA, 64'h3);
    end_burst();
    // Error cases: bad width, bad kind, narrow signed, narrow float, palette, other
    configure(3'd7, rs2r_pkg::KIND_UNSIGNED, rs2r_pkg::MODE_RGB, 3'd3);
    send_pixel('1, '1, '1, '1);
    end_burst();
    configure(3'd3, rs2r_pkg::KIND_BAD, rs2r_pkg::MODE_RGB, 3'd3);
    send_pixel('1, '1, '1, '1);
    end_burst();
    configure(3'd1, rs2r_pkg::KIND_SIGNED, rs2r_pkg::MODE_BLACK_ZERO, 3'd1);
    send_pixel('1, 0, 0, 0);
    end_burst();
    configure(3'd4, rs2r_pkg::KIND_FLOAT, rs2r_pkg::MODE_RGB, 3'd3);
    send_pixel('1, 0, 0, 0);
    end_burst();
    configure(3'd3, rs2r_pkg::KIND_UNSIGNED, rs2r_pkg::MODE_PALETTE, 3'd1);
    send_pixel(64'h12, 0, 0, 0);
    end_burst();
    configure(3'd3, rs2r_pkg::KIND_UNSIGNED, 3'd5, 3'd3);
    send_pixel(64'h12, 64'h34, 64'h56, 64'h78);
    end_burst();

    // Random phases
    for (int phase = 0; phase < 32; phase++) begin
      k = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 15) == 0) k = rs2r_pkg::KIND_BAD;
      case (k)
        rs2r_pkg::KIND_FLOAT:  w = 3'($urandom_range(5, 6));
        rs2r_pkg::KIND_SIGNED: w = 3'($urandom_range(3, 6));
        default:               w = 3'($urandom_range(0, 6));
      endcase
      if ($urandom_range(0, 15) == 0) w = 3'($urandom_range(0, 7));
      m = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 4));
      s = ($urandom_range(0, 2) != 0) ? 3'd4 : 3'($urandom_range(0, 7));
      configure(w, k, m, s);
      allow_idle = !(phase >= 10 && phase < 15);
      for (int i = 0; i < 20; i++) begin
        if (phase == 5 && i == 10) begin
          start <= 1'b0;
          while (pixel_sb.pending() > 0) @(posedge clk_i);
        end
        send_pixel(random_sample(k, w), random_sample(k, w),
                   random_sample(k, w), random_sample(k, w));
      end
      end_burst();
    end

    drain();
    if (pixel_sb.failures == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
